### hw/rtl/assert_macros.svh
// Assertion macros shared by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/ptec_pkg.sv
// Shared types and constants of the TEC duty controller.
package ptec_pkg;

  localparam int TEMP_LOW_LIMIT    = 0;
  localparam int TEMP_HIGH_LIMIT   = 12800;
  localparam int REVERSAL_DWELL_MS = 5000;
  localparam int PWM_FULL_SCALE    = 1023;

  localparam int INTEG_MAX   = 100 * 65536;
  localparam int MS_PER_S    = 1000;
  localparam int BLEED_NUM   = 19;
  localparam int BLEED_DEN   = 20;
  localparam int DUTY_MAX    = 100;
  // |duty| * PWM_FULL_SCALE / 100 as multiply by rounded-up reciprocal, >> 24
  localparam longint PWM_K   = (longint'(PWM_FULL_SCALE) * 64'd16777216 + 64'd99) / 64'd100;
  // x / 20 as (x >> 2) * ceil(2^27 / 5) >> 27, exact for x < 2^27
  localparam longint BLEED_RCP = (64'd134217728 + 64'd4) / 64'd5;
  // x / 1000 as (x >> 3) * ceil(2^38 / 125) >> 38, exact for x < 2^34
  localparam longint MS_RCP    = (64'd274877906944 + 64'd124) / 64'd125;

  typedef enum logic [2:0] {
    ST_REGULATE = 3'd0,
    ST_FAILSAFE = 3'd1,
    ST_DEADBAND = 3'd2,
    ST_DWELL    = 3'd3,
    ST_FORCED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_ENABLE   = 3'd0,
    CFG_TARGET   = 3'd1,
    CFG_DEADZONE = 3'd2,
    CFG_GAIN_P   = 3'd3,
    CFG_GAIN_I   = 3'd4,
    CFG_GAIN_D   = 3'd5,
    CFG_CEILING  = 3'd6,
    CFG_SLEW     = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_OFF,
    OP_REG_START,
    OP_BLEED_START,
    OP_BLEED_DONE,
    OP_PREP,
    OP_MUL_STEP,
    OP_DIVI_START,
    OP_INTEG_UPD,
    OP_DIVD_START,
    OP_DERIV_UPD,
    OP_SUM,
    OP_TARGET,
    OP_FINISH,
    OP_APPLY
  } dp_op_t;

  typedef struct packed {
    logic forced;
    logic fail;
    logic dead;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

endpackage

### hw/rtl/ptec_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ptec_div
  import ptec_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [32:0] trial;

  always_comb begin
    shifted = {rem_r, quo_r[63]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[32]) begin
      rem_nxt = trial[31:0];
      quo_nxt = {quo_r[62:0], 1'b1};
    end else begin
      rem_nxt = shifted[31:0];
      quo_nxt = {quo_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/ptec_datapath.sv
// Datapath: config registers, loop state, PID arithmetic and result payload.
`include "assert_macros.svh"
module ptec_datapath
  import ptec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_op_t             op,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_mode,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_temperature,
  input  logic               in_sensor_fault,
  output logic signed [7:0]  out_duty,
  output logic               out_heat_dir,
  output logic [15:0]        out_pwm_level,
  output logic               out_fan_on,
  output logic [2:0]         out_status
);

  localparam logic signed [15:0] TEMP_LO   = 16'(TEMP_LOW_LIMIT);
  localparam logic signed [15:0] TEMP_HI   = 16'(TEMP_HIGH_LIMIT);
  localparam logic signed [25:0] INTEG_LIM = 26'(INTEG_MAX);
  localparam logic signed [23:0] INTEG_L24 = 24'(INTEG_MAX);

  // configuration
  logic               enable_r;
  logic signed [15:0] target_r;
  logic [11:0]        dead_zone_r;
  logic [15:0]        gain_p_r, gain_i_r, gain_d_r;
  logic [6:0]         ceiling_r, slew_r;

  // captured beat
  logic               mode_r, fault_r;
  logic [31:0]        now_r;
  logic signed [15:0] temp_r;

  // loop state
  logic signed [23:0] integ_r;
  logic signed [16:0] last_err_r;
  logic [31:0]        last_time_r;
  logic signed [7:0]  applied_r;
  logic               heat_dir_r;
  logic [31:0]        last_rev_r;

  // working registers
  logic [31:0]        dt_r;
  logic [31:0]        pi_mag_r;
  logic               pi_neg_r;
  logic [32:0]        dd_mag_r;
  logic               dd_neg_r;
  logic signed [33:0] pp_r;
  logic [42:0]        dd_num_r;
  logic [63:0]        mcand_r, prod_r;
  logic [31:0]        mplier_r;
  logic               bleed_neg_r;
  logic [24:0]        bleed_m_r;
  logic [30:0]        ms_m_r;
  logic               ms_sat_r;
  logic signed [44:0] deriv_r;
  logic signed [46:0] sum_r;
  logic signed [7:0]  tgt_r;
  logic signed [7:0]  pend_duty_r;
  status_t            pend_status_r;

  // result payload
  logic signed [7:0]  o_duty_r;
  logic               o_dir_r, o_fan_r;
  logic [15:0]        o_pwm_r;
  status_t            o_status_r;

  // divider
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;

  ptec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // classification
  logic signed [16:0] err_w;
  logic [16:0]        err_mag;
  logic [31:0]        dt_raw, dt_w;
  logic signed [33:0] pi_w, pp_w;
  logic signed [17:0] derr_w;
  logic signed [34:0] dd_w;
  logic [22:0]        integ_abs;
  logic [27:0]        bleed_num;

  assign err_w   = 17'(target_r) - 17'(temp_r);
  assign err_mag = err_w[16] ? 17'(-err_w) : 17'(err_w);
  assign dt_raw  = now_r - last_time_r;
  assign dt_w    = (dt_raw == 32'd0) ? 32'd1 : dt_raw;
  assign pi_w    = $signed({1'b0, gain_i_r}) * err_w;
  assign pp_w    = $signed({1'b0, gain_p_r}) * err_w;
  assign derr_w  = 18'(err_w) - 18'(last_err_r);
  assign dd_w    = $signed({1'b0, gain_d_r}) * derr_w;
  assign integ_abs = integ_r[23] ? 23'(-integ_r) : integ_r[22:0];
  assign bleed_num = 28'(integ_abs) * 28'(BLEED_NUM);

  assign stat.forced   = mode_r;
  assign stat.fail     = !enable_r || fault_r || (temp_r < TEMP_LO) || (temp_r > TEMP_HI);
  assign stat.dead     = err_mag < {5'd0, dead_zone_r};
  assign stat.mul_done = (mplier_r == 32'd0);
  assign stat.div_done = div_done;

  // only the derivative divides by a variable (dt)
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 32'd1;
    case (op)
      OP_DIVD_START: begin
        div_start    = 1'b1;
        div_dividend = 64'(dd_num_r);
        div_divisor  = dt_r;
      end
      default: ;
    endcase
  end

  // bleed: |integ| * 19 / 20 by reciprocal multiply
  logic [49:0] bleed_prod;
  logic [22:0] bleed_q;
  assign bleed_prod = 50'(bleed_m_r) * 50'(BLEED_RCP);
  assign bleed_q    = bleed_prod[49:27];

  // integral step / 1000 by reciprocal multiply; large products saturate
  logic [62:0] ms_prod;
  logic [24:0] ms_q;
  assign ms_prod = 63'(ms_m_r) * 63'(MS_RCP);
  assign ms_q    = ms_prod[62:38];

  // integral update: saturate the step, add with sign, clamp
  logic [23:0]        inc_w;
  logic signed [25:0] inc_s, isum;
  logic signed [23:0] iclamp;
  assign inc_w = (ms_sat_r || ms_q[24]) ? 24'hFF_FFFF : ms_q[23:0];
  assign inc_s = $signed({2'b00, inc_w});
  assign isum  = 26'(integ_r) + (pi_neg_r ? -inc_s : inc_s);
  always_comb begin
    if (isum > INTEG_LIM)       iclamp = INTEG_L24;
    else if (isum < -INTEG_LIM) iclamp = -INTEG_L24;
    else                        iclamp = 24'(isum);
  end

  logic signed [44:0] qd;
  assign qd = $signed({1'b0, div_q[43:0]});

  // output clamp and truncation toward zero
  logic [45:0] sum_abs;
  logic [6:0]  ceil7, tmag;
  logic [22:0] lim, mag23;
  assign sum_abs = sum_r[46] ? 46'(-sum_r) : sum_r[45:0];
  assign ceil7   = (ceiling_r > 7'(DUTY_MAX)) ? 7'(DUTY_MAX) : ceiling_r;
  assign lim     = {ceil7, 16'd0};
  assign mag23   = (sum_abs > 46'(lim)) ? lim : sum_abs[22:0];
  assign tmag    = mag23[22:16];

  // dwell and slew
  logic [31:0]       elapsed;
  logic              dwell_hold;
  logic signed [8:0] delta, step9, up9, dn9;
  logic signed [7:0] slewed;
  assign elapsed    = now_r - last_rev_r;
  assign dwell_hold = (tgt_r != 8'sd0) && ((!tgt_r[7]) != heat_dir_r)
                      && (elapsed < 32'(REVERSAL_DWELL_MS));
  assign delta = 9'(tgt_r) - 9'(applied_r);
  assign step9 = $signed({2'b00, slew_r});
  assign up9   = 9'(applied_r) + step9;
  assign dn9   = 9'(applied_r) - step9;
  always_comb begin
    if (delta > step9)       slewed = 8'(up9);
    else if (delta < -step9) slewed = 8'(dn9);
    else                     slewed = tgt_r;
  end

  // apply
  logic [6:0]  pend_mag;
  logic [42:0] pwm_prod;
  logic        dir_req, new_dir;
  assign pend_mag = pend_duty_r[7] ? 7'(-pend_duty_r) : pend_duty_r[6:0];
  assign pwm_prod = 43'(pend_mag) * 43'(PWM_K);
  assign dir_req  = !pend_duty_r[7];
  assign new_dir  = (pend_duty_r != 8'sd0) ? dir_req : heat_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      target_r      <= 16'sd6400;
      dead_zone_r   <= 12'd64;
      gain_p_r      <= 16'd2560;
      gain_i_r      <= 16'd128;
      gain_d_r      <= 16'd0;
      ceiling_r     <= 7'd100;
      slew_r        <= 7'd10;
      integ_r       <= '0;
      last_err_r    <= '0;
      last_time_r   <= '0;
      applied_r     <= '0;
      heat_dir_r    <= 1'b1;
      last_rev_r    <= '0;
      mplier_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:   enable_r    <= cfg_data[0];
          CFG_TARGET:   target_r    <= $signed(cfg_data);
          CFG_DEADZONE: dead_zone_r <= cfg_data[11:0];
          CFG_GAIN_P:   gain_p_r    <= cfg_data;
          CFG_GAIN_I:   gain_i_r    <= cfg_data;
          CFG_GAIN_D:   gain_d_r    <= cfg_data;
          CFG_CEILING:  ceiling_r   <= cfg_data[6:0];
          CFG_SLEW:     slew_r      <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (op)
        OP_LOAD: begin
          mode_r  <= in_mode;
          now_r   <= in_now_ms;
          temp_r  <= in_temperature;
          fault_r <= in_sensor_fault;
        end
        OP_OFF: begin
          integ_r       <= '0;
          pend_duty_r   <= '0;
          pend_status_r <= mode_r ? ST_FORCED : ST_FAILSAFE;
        end
        OP_BLEED_START: begin
          last_time_r <= now_r;
          last_err_r  <= err_w;
          bleed_neg_r <= integ_r[23];
          bleed_m_r   <= bleed_num[26:2];
        end
        OP_BLEED_DONE: begin
          integ_r       <= bleed_neg_r ? -$signed({1'b0, bleed_q}) : $signed({1'b0, bleed_q});
          pend_duty_r   <= '0;
          pend_status_r <= ST_DEADBAND;
        end
        OP_REG_START: begin
          last_time_r <= now_r;
          dt_r        <= dt_w;
          last_err_r  <= err_w;
          pi_neg_r    <= pi_w[33];
          pi_mag_r    <= pi_w[33] ? 32'(-pi_w) : pi_w[31:0];
          dd_neg_r    <= dd_w[34];
          dd_mag_r    <= dd_w[34] ? 33'(-dd_w) : dd_w[32:0];
          pp_r        <= pp_w;
        end
        OP_PREP: begin
          dd_num_r <= 43'(dd_mag_r) * 43'(MS_PER_S);
          mcand_r  <= 64'(pi_mag_r);
          mplier_r <= dt_r;
          prod_r   <= '0;
        end
        OP_MUL_STEP: begin
          prod_r   <= prod_r + (mplier_r[0] ? mcand_r : 64'd0);
          mcand_r  <= {mcand_r[62:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[31:1]};
        end
        OP_DIVI_START: begin
          ms_sat_r <= |prod_r[63:34];
          ms_m_r   <= prod_r[33:3];
        end
        OP_INTEG_UPD: integ_r <= iclamp;
        OP_DERIV_UPD: deriv_r <= dd_neg_r ? -qd : qd;
        OP_SUM:       sum_r   <= 47'(pp_r) + 47'(integ_r) + 47'(deriv_r);
        OP_TARGET:    tgt_r   <= sum_r[46] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
        OP_FINISH: begin
          if (dwell_hold) begin
            pend_duty_r   <= '0;
            pend_status_r <= ST_DWELL;
          end else begin
            pend_duty_r   <= slewed;
            pend_status_r <= ST_REGULATE;
          end
        end
        OP_APPLY: begin
          applied_r  <= pend_duty_r;
          heat_dir_r <= new_dir;
          if (new_dir != heat_dir_r) last_rev_r <= now_r;
          o_duty_r   <= pend_duty_r;
          o_dir_r    <= new_dir;
          o_pwm_r    <= pwm_prod[39:24];
          o_fan_r    <= (pend_duty_r != 8'sd0);
          o_status_r <= pend_status_r;
        end
        default: ;
      endcase
    end
  end

  assign out_duty      = o_duty_r;
  assign out_heat_dir  = o_dir_r;
  assign out_pwm_level = o_pwm_r;
  assign out_fan_on    = o_fan_r;
  assign out_status    = o_status_r;

  `ASSERT_ALWAYS(a_integ_range, clk, rst_n, (integ_r <= INTEG_L24) && (integ_r >= -INTEG_L24))
  `ASSERT_ALWAYS(a_duty_range, clk, rst_n, (applied_r <= 8'sd100) && (applied_r >= -8'sd100))
  `ASSERT_NEXT(a_apply_duty, clk, rst_n, op == OP_APPLY, applied_r == $past(pend_duty_r))

endmodule

### hw/rtl/ptec_ctrl.sv
// Controller: sequences one control tick through the datapath, owns the handshakes.
`include "assert_macros.svh"
module ptec_ctrl
  import ptec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_BLEED, S_PREP, S_MUL, S_DIVI, S_DIVD_GO, S_DIVD,
    S_SUM, S_TGT, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        op        = OP_LOAD;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        if (stat.forced || stat.fail) begin
          op        = OP_OFF;
          state_nxt = S_OUT;
        end else if (stat.dead) begin
          op        = OP_BLEED_START;
          state_nxt = S_BLEED;
        end else begin
          op        = OP_REG_START;
          state_nxt = S_PREP;
        end
      end
      S_BLEED: begin
        op        = OP_BLEED_DONE;
        state_nxt = S_OUT;
      end
      S_PREP: begin
        op        = OP_PREP;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (stat.mul_done) begin
          op        = OP_DIVI_START;
          state_nxt = S_DIVI;
        end else begin
          op = OP_MUL_STEP;
        end
      end
      S_DIVI: begin
        op        = OP_INTEG_UPD;
        state_nxt = S_DIVD_GO;
      end
      S_DIVD_GO: begin
        op        = OP_DIVD_START;
        state_nxt = S_DIVD;
      end
      S_DIVD: if (stat.div_done) begin
        op        = OP_DERIV_UPD;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        op        = OP_SUM;
        state_nxt = S_TGT;
      end
      S_TGT: begin
        op        = OP_TARGET;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        op        = OP_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: if (slot_free) begin
        op        = OP_APPLY;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (op == OP_APPLY) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_IMPLY(a_apply_slot, clk, rst_n, op == OP_APPLY, !out_valid_r || !out_stall)
  `ASSERT_NEXT(a_load_class, clk, rst_n, in_valid && !in_stall, state_r == S_CLASS)
  `ASSERT_NEXT(a_mul_to_div, clk, rst_n, (state_r == S_MUL) && stat.mul_done, state_r == S_DIVI)

endmodule

### hw/rtl/pid_tec_duty_controller.sv
// Top level of the TEC duty PID controller: controller FSM plus datapath.
// Path from accepting edge to out_valid: forced-off/failsafe via S_CLASS, S_OUT;
//   deadband via S_CLASS, S_BLEED, S_OUT; regulation adds the shift-add dt multiply
//   and a pass of the one-bit-per-cycle derivative divider. S_OUT waits for a free slot.
// Throughput: one beat at a time; next beat is taken once the result is registered.
// Reset: synchronous active-low rst_n; config to defaults, integral/history cleared.
module pid_tec_duty_controller
  import ptec_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input beat: one control tick
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_temperature,
  input  logic               in_sensor_fault,
  // result beat
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_duty,
  output logic               out_heat_dir,
  output logic [15:0]        out_pwm_level,
  output logic               out_fan_on,
  output logic [2:0]         out_status,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  dp_op_t   op;
  dp_stat_t stat;

  // registers are always writable; software writes only while idle
  assign cfg_ready = 1'b1;

  ptec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .op        (op)
  );

  // datapath holds config, integral/derivative history, direction latch
  // and the result payload register
  ptec_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mode         (in_mode),
    .in_now_ms       (in_now_ms),
    .in_temperature  (in_temperature),
    .in_sensor_fault (in_sensor_fault),
    .out_duty        (out_duty),
    .out_heat_dir    (out_heat_dir),
    .out_pwm_level   (out_pwm_level),
    .out_fan_on      (out_fan_on),
    .out_status      (out_status)
  );

endmodule

### bench/tb_pid_tec_duty_controller.sv
// Self-checking testbench for the TEC duty PID controller.
`timescale 1ns / 100ps

module tb_pid_tec_duty_controller;
  import ptec_pkg::*;

  // One result beat as seen on the out_ port.
  typedef struct {
    logic signed [7:0] duty;
    logic              heat_dir;
    logic [15:0]       pwm_level;
    logic              fan_on;
    logic [2:0]        status;
  } tick_result_t;

  // Duty predictor plus queue of expected result beats.
  class duty_scoreboard;
    // register copy
    int unsigned enable, dead_zone, kp, ki, kd, ceiling, slew;
    int          target;
    // controller state copy
    longint      integ;
    int          last_err;
    bit [31:0]   last_t, last_rev;
    int          applied;
    bit          dir;
    tick_result_t expected_q[$];
    int          errors;

    function void reset_state();
      enable = 0; target = 6400; dead_zone = 64; kp = 2560; ki = 128; kd = 0;
      ceiling = 100; slew = 10;
      integ = 0; last_err = 0; last_t = 0; applied = 0; dir = 1; last_rev = 0;
      expected_q.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] d);
      case (idx)
        CFG_ENABLE:   enable = d[0];
        CFG_TARGET:   target = $signed(d);
        CFG_DEADZONE: dead_zone = d[11:0];
        CFG_GAIN_P:   kp = d;
        CFG_GAIN_I:   ki = d;
        CFG_GAIN_D:   kd = d;
        CFG_CEILING:  ceiling = d[6:0];
        CFG_SLEW:     slew = d[6:0];
        default: ;
      endcase
    endfunction

    // Latch duty, track direction changes, queue the beat.
    function void push_duty(int d, bit [31:0] now, status_t st);
      tick_result_t r;
      int mag;
      applied = d;
      if (d != 0 && (d > 0) != dir) begin
        dir = (d > 0);
        last_rev = now;
      end
      mag = d < 0 ? -d : d;
      r.duty = d[7:0];
      r.heat_dir = dir;
      r.pwm_level = 16'((longint'(mag) * PWM_FULL_SCALE) / 100);
      r.fan_on = (d != 0);
      r.status = st;
      expected_q.push_back(r);
    endfunction

    function void note_tick(bit mode, bit [31:0] now, logic signed [15:0] temp_q, bit fault);
      int          temp, err, tgt, delta;
      bit [31:0]   dt;
      longint      p, inc, deriv, sum, lim;
      bit [63:0]   mag;
      temp = temp_q;
      if (mode) begin
        integ = 0;
        push_duty(0, now, ST_FORCED);
        return;
      end
      if (enable == 0 || fault || temp < TEMP_LOW_LIMIT || temp > TEMP_HIGH_LIMIT) begin
        integ = 0;
        push_duty(0, now, ST_FAILSAFE);
        return;
      end
      dt = now - last_t;
      if (dt == 0) dt = 1;
      last_t = now;
      err = target - temp;
      if ((err < 0 ? -err : err) < dead_zone) begin
        integ = integ * 19 / 20;
        last_err = err;
        push_duty(0, now, ST_DEADBAND);
        return;
      end
      // integral step: floor(|ki*err| * dt / 1000), signed like err
      p = longint'(ki) * err;
      mag = p < 0 ? -p : p;
      inc = longint'(mag * (dt / 1000) + mag * (dt % 1000) / 1000);
      if (p < 0) inc = -inc;
      integ = integ + inc;
      if (integ > INTEG_MAX) integ = INTEG_MAX;
      if (integ < -INTEG_MAX) integ = -INTEG_MAX;
      deriv = longint'(kd) * (longint'(err) - last_err) * 1000 / longint'({32'd0, dt});
      last_err = err;
      sum = longint'(kp) * err + integ + deriv;
      lim = longint'(ceiling > 100 ? 100 : ceiling) * 65536;
      if (sum > lim) sum = lim;
      if (sum < -lim) sum = -lim;
      tgt = int'(sum / 65536);
      if (tgt != 0 && (tgt > 0) != dir && (now - last_rev) < REVERSAL_DWELL_MS) begin
        push_duty(0, now, ST_DWELL);
        return;
      end
      delta = tgt - applied;
      if (delta > int'(slew)) tgt = applied + slew;
      if (delta < -int'(slew)) tgt = applied - slew;
      push_duty(tgt, now, ST_REGULATE);
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat duty=%0d status=%0d", $time, got.duty,
                 got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.duty !== want.duty) begin
        $display("%0t: duty exp %0d got %0d", $time, want.duty, got.duty);
        errors++;
      end
      if (got.heat_dir !== want.heat_dir) begin
        $display("%0t: heat_dir exp %0d got %0d", $time, want.heat_dir, got.heat_dir);
        errors++;
      end
      if (got.pwm_level !== want.pwm_level) begin
        $display("%0t: pwm_level exp %0d got %0d", $time, want.pwm_level, got.pwm_level);
        errors++;
      end
      if (got.fan_on !== want.fan_on) begin
        $display("%0t: fan_on exp %0d got %0d", $time, want.fan_on, got.fan_on);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1000000;

  logic               clk = 0;
  logic               rst_n;
  logic               in_valid, in_stall, in_mode, in_sensor_fault;
  logic [31:0]        in_now_ms;
  logic signed [15:0] in_temperature;
  logic               out_valid, out_stall, out_heat_dir, out_fan_on;
  logic signed [7:0]  out_duty;
  logic [15:0]        out_pwm_level;
  logic [2:0]         out_status;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  duty_scoreboard sb = new();
  bit        quiet;          // no idling on either side in the closing stretch
  int        stall_left;
  int        cycles;
  bit [31:0] clock_ms;       // running timestamp for well-formed tick streams

  pid_tec_duty_controller dut (.*);

  always #5 clk = ~clk;

  initial begin
    rst_n <= 0;
    in_valid <= 0; in_mode <= 0; in_now_ms <= 0; in_temperature <= 0;
    in_sensor_fault <= 0;
    out_stall <= 0;
    cfg_valid <= 0; cfg_index <= CFG_ENABLE; cfg_data <= 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 0;
    end
  end

  // result monitor: a beat moves when out_valid && !out_stall at the edge
  always @(posedge clk) begin
    tick_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.duty = out_duty;
      got.heat_dir = out_heat_dir;
      got.pwm_level = out_pwm_level;
      got.fan_on = out_fan_on;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  // Present one tick; hold it until taken, then maybe idle a burst.
  task automatic send_tick(bit mode, bit [31:0] now, logic signed [15:0] temp, bit fault);
    in_valid <= 1;
    in_mode <= mode;
    in_now_ms <= now;
    in_temperature <= temp;
    in_sensor_fault <= fault;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(mode, now, temp, fault);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Regulating tick at the running clock, advanced by step_ms.
  task automatic tick_at(int unsigned step_ms, logic signed [15:0] temp);
    clock_ms = clock_ms + step_ms;
    send_tick(0, clock_ms, temp, 0);
  endtask

  // Drain: lower valid, wait for every pending result, then idle before returning.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] en, logic [15:0] tgt, logic [15:0] dz,
                           logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                           logic [15:0] ceil_pct, logic [15:0] slew_pct);
    drain();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_CEILING, ceil_pct);
    write_reg(CFG_SLEW, slew_pct);
  endtask

  // Random tick: mostly well-formed regulation across the sensor window, some noise.
  task automatic random_tick();
    int unsigned sel;
    logic signed [15:0] temp;
    bit [31:0] now;
    bit mode, fault;
    sel = $urandom_range(0, 99);
    mode = (sel < 4);
    fault = (sel >= 4 && sel < 8);
    if (sel < 90)
      temp = 16'($urandom_range(0, 12800));
    else if (sel < 95)
      temp = 16'(sb.target + $signed($urandom_range(0, 512)) - 256);
    else
      temp = 16'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 80) clock_ms = clock_ms + $urandom_range(1, 2500);
    else if (sel < 88) clock_ms = clock_ms + $urandom_range(5000, 20000);
    else if (sel < 95) clock_ms = $urandom;
    now = clock_ms;
    send_tick(mode, now, temp, fault);
  endtask

  initial begin
    int k;
    sb.reset_state();
    quiet = 0;
    cycles = 0;
    clock_ms = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // --- directed ---
    // reset defaults: disabled, so failsafe; then forced off
    send_tick(0, 32'd100, 16'sd6400, 0);
    send_tick(1, 32'hFFFF_FFFF, -16'sd32768, 1);
    write_all(1, 6400, 64, 2560, 128, 256, 100, 10);
    send_tick(0, 0, 16'sd6400, 0);                 // deadband
    send_tick(0, 0, 16'sd0, 0);                    // heat, equal timestamps
    send_tick(0, 10, 16'sd0, 0);                   // slew ramp
    send_tick(0, 20, 16'sd12800, 0);               // reversal inside dwell
    send_tick(0, 6000, 16'sd12800, 0);             // reversal allowed
    send_tick(0, 6000, 16'sd12800, 0);
    send_tick(0, 6100, -16'sd1, 0);                // below window
    send_tick(0, 6200, 16'sd12801, 0);             // above window
    send_tick(0, 6300, 16'sd32767, 0);
    send_tick(0, 6400, 16'sd6400, 1);              // sensor fault
    send_tick(1, 6500, 16'sd6400, 0);              // forced off wins
    send_tick(0, 32'hFFFF_FF00, 16'sd100, 0);      // large dt
    send_tick(0, 32'h0000_0100, 16'sd100, 0);      // wrapped dt
    // extremes: full gains, max deadband, ceiling and slew above 100
    write_all(1, 16'h7FFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 127, 127);
    send_tick(0, 1000, 16'sd0, 0);
    send_tick(0, 1001, 16'sd12800, 0);
    send_tick(0, 9000, 16'sd12800, 0);
    write_all(1, 16'h8000, 0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    send_tick(0, 9100, 16'sd12800, 0);             // ceiling zero
    write_all(1, 16'h8000, 0, 16'hFFFF, 16'hFFFF, 0, 100, 100);
    send_tick(0, 9200, 16'sd12800, 0);
    send_tick(0, 9300, 16'sd6400, 0);
    // sender holds off until every pending result has come back
    drain();
    send_tick(0, 9400, 16'sd0, 0);

    // --- random phases ---
    for (k = 0; k < 7; k++) begin
      write_all(16'($urandom_range(0, 7) != 0), 16'($urandom_range(0, 12800)),
                16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 256)),
                16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 4096)),
                16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1024)),
                16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 512)),
                16'($urandom_range(0, 127)), 16'($urandom_range(0, 127)));
      repeat (60) random_tick();
      if (k == 6) quiet = 1;
    end
    repeat (30) random_tick();

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0t: %0d result beats never arrived", $time, sb.expected_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule
